/* sv/classification_accuracy_counter_assert.svh */
// Assertion macros used by the checker of the accuracy counter.
`ifndef CLASSIFICATION_ACCURACY_COUNTER_ASSERT_SVH
`define CLASSIFICATION_ACCURACY_COUNTER_ASSERT_SVH

// Require prop in the same cycle whenever cond holds.
`define CAC_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("accuracy counter check failed");

// Require prop in the cycle after cond holds.
`define CAC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("accuracy counter check failed");

`endif

/* sv/cac_pkg.sv */
package cac_pkg;

  // Parameter defaults
  localparam int MAX_CLASSES_DEF = 64;
  localparam int MAX_SAMPLES_DEF = 65535;

  // Field widths
  localparam int VAL_W   = 24;
  localparam int NCLS_W  = 7;
  localparam int CLASS_W = 6;
  localparam int COUNT_W = 16;
  localparam int ACC_W   = 17;

  // Q7.16 constants
  localparam logic signed [VAL_W-1:0] Q_ONE       = 24'sd65536;
  localparam logic signed [VAL_W-1:0] Q_HALF      = 24'sd32768;
  localparam logic signed [VAL_W-1:0] Q_MINUS_ONE = -24'sd65536;

  // Long division: quotient bits produced one per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [VAL_W-1:0] score;
    logic signed [VAL_W-1:0] expected;
    logic                    end_of_batch;
  } in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_idx;
    logic               has_prediction;
    logic               sample_correct;
    logic [COUNT_W-1:0] correct_count;
    logic [COUNT_W-1:0] sample_count;
    logic [ACC_W-1:0]   accuracy;
    logic               batch_done;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic take;
    logic div_step;
    logic load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic closes_sample;
    logic end_of_batch;
    logic out_free;
  } status_t;

endpackage

/* sv/cac_ctrl.sv */
module cac_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cac_pkg::status_t status,
  output cac_pkg::cmd_t    cmd
);
  import cac_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;

  assign in_ready = (state == ST_IDLE);

  // Sequence one transaction: take it, divide at batch end, hand off the result
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd.take     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.load     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (status.closes_sample) begin
            if (status.end_of_batch) begin
              state_next = ST_DIV;
              cnt_next   = '0;
            end else begin
              state_next = ST_LOAD;
            end
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

/* sv/cac_datapath.sv */
module cac_datapath #(
  parameter int MAX_CLASSES = cac_pkg::MAX_CLASSES_DEF,
  parameter int MAX_SAMPLES = cac_pkg::MAX_SAMPLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cac_pkg::in_t                in_data,
  input  logic                        cfg_valid,
  input  logic [cac_pkg::NCLS_W-1:0]  cfg_data,
  input  cac_pkg::cmd_t               cmd,
  output cac_pkg::status_t            status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cac_pkg::out_t               out_data
);
  import cac_pkg::*;

  localparam int ROW_W = $clog2(MAX_CLASSES + 1);
  localparam int EFF_W = (ROW_W > NCLS_W) ? ROW_W : NCLS_W;
  localparam logic [EFF_W-1:0] CLASS_CAP = EFF_W'(MAX_CLASSES);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
    COUNT_W'((MAX_SAMPLES < 65535) ? MAX_SAMPLES : 65535);

  // Configuration and per-sample state
  logic [NCLS_W-1:0]       num_classes;
  logic [ROW_W-1:0]        row_position;
  logic signed [VAL_W-1:0] running_max;
  logic [ROW_W-1:0]        max_row;
  logic                    winner_seen;
  logic [1:0]              expected_ones;
  logic [ROW_W-1:0]        expected_one_row;
  logic                    expected_bad;
  logic [COUNT_W-1:0]      correct_total;
  logic [COUNT_W-1:0]      sample_total;

  // Result staging and divider
  out_t                    res;
  out_t                    res_final;
  logic [DIV_STEPS-1:0]    quo;
  logic [COUNT_W-1:0]      rem;

  // Next values
  logic [EFF_W-1:0]        ncls_eff;
  logic                    binary_mode;
  logic signed [VAL_W-1:0] sc;
  logic signed [VAL_W-1:0] ev;
  logic                    eob;
  logic                    exp_one;
  logic                    exp_zero;
  logic signed [VAL_W-1:0] running_max_next;
  logic [ROW_W-1:0]        max_row_next;
  logic                    winner_seen_next;
  logic [1:0]              expected_ones_next;
  logic [ROW_W-1:0]        expected_one_row_next;
  logic                    expected_bad_next;
  logic [ROW_W-1:0]        row_inc;
  logic                    closes;
  logic                    ok;
  logic [CLASS_W-1:0]      pred;
  logic                    hasp;
  logic [COUNT_W-1:0]      sample_total_next;
  logic [COUNT_W-1:0]      correct_total_next;
  logic [COUNT_W:0]        rem_sh;
  logic                    q_bit;

  // Evaluate one row against the running sample state
  always_comb begin
    sc  = in_data.score;
    ev  = in_data.expected;
    eob = in_data.end_of_batch;

    if (num_classes == '0) begin
      ncls_eff = EFF_W'(1);
    end else if (EFF_W'(num_classes) > CLASS_CAP) begin
      ncls_eff = CLASS_CAP;
    end else begin
      ncls_eff = EFF_W'(num_classes);
    end
    binary_mode = (ncls_eff == EFF_W'(1));

    // Strictly greater takes over, so ties keep the first row
    running_max_next = running_max;
    max_row_next     = max_row;
    winner_seen_next = winner_seen;
    if (sc > running_max) begin
      running_max_next = sc;
      max_row_next     = row_position;
      winner_seen_next = 1'b1;
    end

    exp_one               = (ev == Q_ONE);
    exp_zero              = (ev == '0);
    expected_ones_next    = expected_ones;
    expected_one_row_next = expected_one_row;
    if (exp_one) begin
      if (expected_ones == 2'd0) begin
        expected_one_row_next = row_position;
      end
      if (expected_ones != 2'd2) begin
        expected_ones_next = expected_ones + 2'd1;
      end
    end
    expected_bad_next = expected_bad | (!exp_one && !exp_zero);

    row_inc = row_position + 1'b1;
    closes  = binary_mode || eob || (EFF_W'(row_inc) >= ncls_eff);

    if (binary_mode) begin
      pred = CLASS_W'(sc >= Q_HALF);
      hasp = 1'b1;
      ok   = ((sc >= Q_HALF) == (ev >= Q_HALF));
    end else begin
      pred = winner_seen_next ? CLASS_W'(max_row_next) : '0;
      hasp = winner_seen_next;
      if (expected_bad_next) begin
        ok = 1'b0;
      end else if (winner_seen_next) begin
        ok = (expected_ones_next == 2'd1) && (expected_one_row_next == max_row_next);
      end else begin
        ok = (expected_ones_next == 2'd0);
      end
    end

    // Saturating batch counts
    sample_total_next  = (sample_total < COUNT_LIMIT) ? sample_total + 1'b1 : sample_total;
    correct_total_next = (ok && correct_total < COUNT_LIMIT) ?
                         correct_total + 1'b1 : correct_total;

    // One restoring division step
    rem_sh = {rem, quo[DIV_STEPS-1]};
    q_bit  = (rem_sh >= {1'b0, res.sample_count});

    // Attach the accuracy only to the batch-closing result
    res_final          = res;
    res_final.accuracy = res.batch_done ? quo[ACC_W-1:0] : '0;

    status.closes_sample = closes;
    status.end_of_batch  = eob;
    status.out_free      = !out_valid || out_ready;
  end

  // Control state: configuration, sample tracking, batch counts, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes      <= NCLS_W'(1);
      row_position     <= '0;
      running_max      <= Q_MINUS_ONE;
      max_row          <= '0;
      winner_seen      <= 1'b0;
      expected_ones    <= 2'd0;
      expected_one_row <= '0;
      expected_bad     <= 1'b0;
      correct_total    <= '0;
      sample_total     <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        // A new class count drops the partial sample
        num_classes      <= cfg_data;
        row_position     <= '0;
        running_max      <= Q_MINUS_ONE;
        max_row          <= '0;
        winner_seen      <= 1'b0;
        expected_ones    <= 2'd0;
        expected_one_row <= '0;
        expected_bad     <= 1'b0;
      end else if (cmd.take) begin
        if (closes) begin
          row_position     <= '0;
          running_max      <= Q_MINUS_ONE;
          max_row          <= '0;
          winner_seen      <= 1'b0;
          expected_ones    <= 2'd0;
          expected_one_row <= '0;
          expected_bad     <= 1'b0;
          correct_total    <= eob ? '0 : correct_total_next;
          sample_total     <= eob ? '0 : sample_total_next;
        end else begin
          row_position     <= row_inc;
          running_max      <= running_max_next;
          max_row          <= max_row_next;
          winner_seen      <= winner_seen_next;
          expected_ones    <= expected_ones_next;
          expected_one_row <= expected_one_row_next;
          expected_bad     <= expected_bad_next;
        end
      end

      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: stage the result, run the divider, fill the output register
  always_ff @(posedge clk) begin
    if (cmd.take && closes) begin
      res.class_idx      <= pred;
      res.has_prediction <= hasp;
      res.sample_correct <= ok;
      res.correct_count  <= correct_total_next;
      res.sample_count   <= sample_total_next;
      res.accuracy       <= '0;
      res.batch_done     <= eob;
      // correct * 2^16 + floor(total / 2)
      quo <= {correct_total_next, 1'b0, sample_total_next[COUNT_W-1:1]};
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= q_bit ? COUNT_W'(rem_sh - {1'b0, res.sample_count}) : COUNT_W'(rem_sh);
      quo <= {quo[DIV_STEPS-2:0], q_bit};
    end

    if (cmd.load) begin
      out_data <= res_final;
    end
  end

endmodule

/* sv/classification_accuracy_counter.sv */
// A row that does not end a sample is absorbed when it is taken. After a sample-ending row
// is accepted the controller waits in LOAD and out_valid rises once the output register is
// free; at batch end the 32-step divider runs first. Rows within a sample are taken at 1
// row per cycle; after a closing row no new row is taken until its result is loaded.
// Reset (rst, synchronous): class count 1, sample state and batch counts cleared, no
// result pending. Configuration writes are taken in every cycle.
module classification_accuracy_counter #(
  parameter int MAX_CLASSES = cac_pkg::MAX_CLASSES_DEF,
  parameter int MAX_SAMPLES = cac_pkg::MAX_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  cac_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output cac_pkg::out_t              out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cac_pkg::NCLS_W-1:0] cfg_data
);
  import cac_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Register writes never stall
  assign cfg_ready = 1'b1;

  cac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cac_datapath #(
    .MAX_CLASSES (MAX_CLASSES),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sv/cac_checker.sv */
module cac_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input cac_pkg::out_t out_data
);
  import cac_pkg::*;

  `include "classification_accuracy_counter_assert.svh"

  // Hold a stalled result transaction
  `CAC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // Accuracy is only reported at batch end
  `CAC_ASSERT_SAME(a_acc_zero, out_valid && !out_data.batch_done, out_data.accuracy == '0)
  // Correct samples never outnumber samples
  `CAC_ASSERT_SAME(a_counts, out_valid, out_data.correct_count <= out_data.sample_count)
  // The fraction stays within one
  `CAC_ASSERT_SAME(a_acc_range, out_valid, out_data.accuracy <= 17'd65536)
  // No winner reports class zero
  `CAC_ASSERT_SAME(a_no_pred, out_valid && !out_data.has_prediction, out_data.class_idx == '0)

endmodule

bind classification_accuracy_counter cac_checker u_cac_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
